@@ rtl/dtb_pkg.sv @@
// dtb_pkg: shared types, constants and codes of the deadline timer bank
// depends on nothing; imported by dtb_period_calc and deadline_timer_bank
`default_nettype none

package dtb_pkg;

  localparam int unsigned NumTimersDef = 16;
  localparam int unsigned OpW          = 3;
  localparam int unsigned IdxW         = 4;
  localparam int unsigned MsW          = 20;
  localparam int unsigned CpuW         = 12;
  localparam int unsigned TimeW        = 63;
  localparam int unsigned PeriodW      = 42;
  localparam int unsigned ProdW        = MsW + CpuW;
  localparam int unsigned MsToUs       = 1000;
  localparam logic [CpuW-1:0]  CpuResetVal = CpuW'(1000);
  localparam logic [TimeW-1:0] TimeMax     = {TimeW{1'b1}};

  typedef enum logic [OpW-1:0] {
    OP_START      = 3'd0,
    OP_RESTART    = 3'd1,
    OP_STOP       = 3'd2,
    OP_FORCE_STOP = 3'd3,
    OP_SET_PERIOD = 3'd4,
    OP_SCAN       = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    MODE_STOPPED = 2'd0,
    MODE_RUNNING = 2'd1,
    MODE_EXPIRED = 2'd2
  } mode_e;

  typedef struct packed {
    logic [OpW-1:0]   operation;
    logic [IdxW-1:0]  timer_index;
    logic [MsW-1:0]   period_ms;
    logic [TimeW-1:0] now;
  } in_item_t;

  typedef struct packed {
    logic             expired_valid;
    logic [IdxW-1:0]  expired_index;
    logic [TimeW-1:0] next_deadline;
    logic             last;
  } out_item_t;

  // one word of the timer memory
  typedef struct packed {
    mode_e              mode;
    logic [PeriodW-1:0] period;
    logic [TimeW-1:0]   deadline;
  } timer_entry_t;

  localparam int unsigned EntryW = $bits(timer_entry_t);

endpackage

`default_nettype wire

@@ rtl/dtb_ram.sv @@
// dtb_ram: generic single-write, single-read memory with registered read data
// no dependencies
`default_nettype none

module dtb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ rtl/dtb_period_calc.sv @@
// dtb_period_calc: two-stage multiplier, period_ms * cycles_per_us * 1000
// depends on dtb_pkg
`default_nettype none

module dtb_period_calc import dtb_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               load_i,
  input  wire logic [MsW-1:0]     period_ms_i,
  input  wire logic [CpuW-1:0]    cpu_i,
  output logic      [PeriodW-1:0] period_o
);

  logic [ProdW-1:0]   prod1_q;
  logic [PeriodW-1:0] prod2_q;

  // stage 1: ms times clock rate, stage 2: times the ms-to-us factor
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod1_q <= ProdW'(period_ms_i) * ProdW'(cpu_i);
    end
    prod2_q <= PeriodW'(prod1_q) * PeriodW'(MsToUs);
  end

  assign period_o = prod2_q;

endmodule

`default_nettype wire

@@ rtl/deadline_timer_bank.sv @@
// deadline_timer_bank: bank of one-shot timers with an earliest-deadline scan
// depends on dtb_pkg, dtb_ram and dtb_period_calc
// operation: a timer operation passes the read, execute and respond states before its
//   result is loaded into the output register (an unaddressable index or an unused code
//   goes straight to respond); a scan walks the timer memory one entry per cycle while
//   no expiry waits for a stalled output register, then gives its final result
// throughput: one item at a time; the input stalls until the final result is loaded
// reset: all timers stopped with zero period and deadline, earliest deadline at maximum
`default_nettype none

module deadline_timer_bank import dtb_pkg::*; #(
  parameter int unsigned NUM_TIMERS = NumTimersDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  // configuration: cycles per microsecond
  input  wire logic            cfg_we_i,
  input  wire logic [CpuW-1:0] cfg_wdata_i,
  // input channel
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire in_item_t        in_item_i,
  // output channel
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output out_item_t            out_item_o
);

  localparam int unsigned AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_RD   = 5'b00010,
    ST_EXEC = 5'b00100,
    ST_SCAN = 5'b01000,
    ST_RESP = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // configuration register
  logic [CpuW-1:0] cpu_q;

  // latched item
  op_e              op_q;
  logic [AW-1:0]    idx_q;
  logic [TimeW-1:0] now_q;

  // scan walk position, earliest deadline
  logic [AW-1:0]    chk_q, chk_d;
  logic [TimeW-1:0] earliest_q, earliest_d;

  // entry valid bits: an entry never written reads as its reset value
  logic [NUM_TIMERS-1:0] valid_q;
  logic                  rvalid_q;

  // read-modify-write path
  logic [AW-1:0]     rd_addr;
  logic [EntryW-1:0] rdata;
  timer_entry_t      rentry;
  timer_entry_t      entry_q;
  logic [TimeW:0]    sum_q;
  logic [TimeW-1:0]  arm_deadline;
  logic              wr_en;
  timer_entry_t      wr_entry;
  logic [AW-1:0]     wr_addr;

  logic [PeriodW-1:0] period_new;

  // output register
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q, out_item_d;
  logic      out_load;
  logic      out_free;

  logic in_xfer;
  logic idx_ok;
  logic op_known;
  logic scan_last;
  logic scan_expire;
  logic scan_running;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  assign idx_ok   = (32'(in_item_i.timer_index) < NUM_TIMERS);
  assign op_known = (in_item_i.operation inside {OP_START, OP_RESTART, OP_STOP,
                                                 OP_FORCE_STOP, OP_SET_PERIOD});

  // read data of an entry that was never written counts as stopped and zero
  assign rentry = rvalid_q ? timer_entry_t'(rdata) : timer_entry_t'('0);

  // scan decisions on the entry whose read data is present now
  assign scan_last    = (chk_q == AW'(NUM_TIMERS - 1));
  assign scan_running = (rentry.mode == MODE_RUNNING);
  assign scan_expire  = scan_running && (rentry.deadline < now_q);

  // saturated now + period, sum registered in the read state
  assign arm_deadline = sum_q[TimeW] ? TimeMax : sum_q[TimeW-1:0];

  dtb_period_calc u_period (
    .clk_i       (clk_i),
    .load_i      (in_xfer),
    .period_ms_i (in_item_i.period_ms),
    .cpu_i       (cpu_q),
    .period_o    (period_new)
  );

  dtb_ram #(
    .Width (EntryW),
    .Depth (NUM_TIMERS)
  ) u_timer_mem (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_entry),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  // read address: the addressed timer, or the scan walk position
  always_comb begin
    rd_addr = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (in_item_i.operation == OP_SCAN) begin
          rd_addr = '0;
        end else begin
          rd_addr = AW'(in_item_i.timer_index);
        end
      end
      ST_SCAN: begin
        // hold the same entry while an expiry waits for the output register
        if (scan_expire && !out_free) begin
          rd_addr = chk_q;
        end else if (scan_last) begin
          rd_addr = '0;
        end else begin
          rd_addr = chk_q + AW'(1);
        end
      end
      default: begin
        rd_addr = idx_q;
      end
    endcase
  end

  // main sequencer
  always_comb begin
    state_d    = state_q;
    chk_d      = chk_q;
    earliest_d = earliest_q;
    wr_en      = 1'b0;
    wr_addr    = idx_q;
    wr_entry   = entry_q;
    out_load   = 1'b0;
    out_item_d = out_item_q;

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_item_i.operation == OP_SCAN) begin
            earliest_d = TimeMax;
            chk_d      = '0;
            state_d    = ST_SCAN;
          end else if (idx_ok && op_known) begin
            state_d = ST_RD;
          end else begin
            // nothing changes, only the ordinary result
            state_d = ST_RESP;
          end
        end
      end

      ST_RD: begin
        state_d = ST_EXEC;
      end

      ST_EXEC: begin
        wr_en = 1'b1;
        case (op_q)
          OP_START: begin
            if (entry_q.mode == MODE_STOPPED) begin
              wr_entry.deadline = arm_deadline;
              wr_entry.mode     = MODE_RUNNING;
              if (arm_deadline < earliest_q) begin
                earliest_d = arm_deadline;
              end
            end
          end
          OP_RESTART: begin
            if (entry_q.mode == MODE_STOPPED || entry_q.mode == MODE_EXPIRED) begin
              wr_entry.deadline = arm_deadline;
              wr_entry.mode     = MODE_RUNNING;
              if (arm_deadline < earliest_q) begin
                earliest_d = arm_deadline;
              end
            end
          end
          OP_STOP: begin
            if (entry_q.mode == MODE_RUNNING) begin
              wr_entry.mode = MODE_STOPPED;
            end
          end
          OP_FORCE_STOP: begin
            wr_entry.mode = MODE_STOPPED;
          end
          OP_SET_PERIOD: begin
            // a running timer keeps its deadline
            wr_entry.period = period_new;
          end
          default: begin
            wr_en = 1'b0;
          end
        endcase
        state_d = ST_RESP;
      end

      ST_SCAN: begin
        wr_addr  = chk_q;
        wr_entry = rentry;
        if (scan_expire) begin
          if (out_free) begin
            wr_en                    = 1'b1;
            wr_entry.mode            = MODE_EXPIRED;
            out_load                 = 1'b1;
            out_item_d.expired_valid = 1'b1;
            out_item_d.expired_index = IdxW'(chk_q);
            out_item_d.next_deadline = '0;
            out_item_d.last          = 1'b0;
          end
        end else if (scan_running && (rentry.deadline < earliest_q)) begin
          earliest_d = rentry.deadline;
        end
        // advance unless an expiry is held back
        if (!scan_expire || out_free) begin
          if (scan_last) begin
            state_d = ST_RESP;
          end else begin
            chk_d = chk_q + AW'(1);
          end
        end
      end

      ST_RESP: begin
        if (out_free) begin
          out_load                 = 1'b1;
          out_item_d.expired_valid = 1'b0;
          out_item_d.expired_index = '0;
          out_item_d.next_deadline = earliest_q;
          out_item_d.last          = 1'b1;
          state_d                  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output register: loaded when free, cleared once transferred
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cpu_q       <= CpuResetVal;
      earliest_q  <= TimeMax;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      chk_q       <= '0;
    end else begin
      state_q     <= state_d;
      earliest_q  <= earliest_d;
      out_valid_q <= out_valid_d;
      chk_q       <= chk_d;
      if (cfg_we_i) begin
        cpu_q <= cfg_wdata_i;
      end
      if (wr_en) begin
        valid_q[wr_addr] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rvalid_q <= valid_q[rd_addr];
    if (in_xfer) begin
      op_q  <= op_e'(in_item_i.operation);
      idx_q <= AW'(in_item_i.timer_index);
      now_q <= in_item_i.now;
    end
    if (state_q == ST_RD) begin
      entry_q <= rentry;
      sum_q   <= {1'b0, now_q} + (TimeW + 1)'(rentry.period);
    end
    if (out_load) begin
      out_item_q <= out_item_d;
    end
  end

endmodule

`default_nettype wire
